/* src/bmhq_pkg.sv */
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants of the binary min-heap priority queue: command
// and status codes, controller states and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bmhq_pkg;

   // Key and field widths.
   localparam int KEY_W = 32;
   localparam int CMD_W = 2;
   localparam int STAT_W = 2;
   localparam int CAP_W = 9;
   localparam int OCC_W = 9;

   // Default number of entries in the heap store.
   localparam int DEPTH_DEFAULT = 256;

   // Reset value of the capacity register.
   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   // Most negative key, returned when the queue is empty.
   localparam logic [KEY_W-1:0] SENTINEL_KEY = 32'h8000_0000;

   // Command codes of an input transaction.
   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT     = 2'd0,
      CMD_DELETE_MIN = 2'd1,
      CMD_FIND_MIN   = 2'd2,
      CMD_MAKE_EMPTY = 2'd3
   } cmd_type;

   // Status codes of a result transaction.
   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_CHK,
      ST_INS_CMP,
      ST_FIND_WAIT,
      ST_DEL_CAP,
      ST_DEL_CHK,
      ST_DEL_CMP
   } state_type;

   // Which store entries the datapath reads this cycle.
   typedef enum logic [2:0] {
      RD_NONE,
      RD_ROOT,
      RD_PARENT,
      RD_ROOT_LAST,
      RD_CHILDREN
   } rd_sel_type;

   // What the datapath writes into the hole this cycle.
   typedef enum logic [1:0] {
      WR_NONE,
      WR_KEY,
      WR_PARENT,
      WR_CHILD
   } wr_sel_type;

   // Next value of the hole position.
   typedef enum logic [2:0] {
      HOLE_HOLD,
      HOLE_NEW,
      HOLE_ROOT,
      HOLE_PARENT,
      HOLE_CHILD
   } hole_sel_type;

   // Next value of the entry count.
   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_CLR
   } cnt_sel_type;

   // Loading of the moving key (and of the minimum on delete).
   typedef enum logic [1:0] {
      KEY_HOLD,
      KEY_REQ,
      KEY_LAST
   } key_sel_type;

   // Result produced this cycle, if any.
   typedef enum logic [2:0] {
      RSP_NONE,
      RSP_OK,
      RSP_FULL,
      RSP_EMPTY,
      RSP_MIN,
      RSP_ROOT
   } rsp_sel_type;

   // Command bundle from the controller to the datapath.
   typedef struct packed {
      rd_sel_type   rd_sel;
      wr_sel_type   wr_sel;
      hole_sel_type hole_sel;
      cnt_sel_type  cnt_sel;
      key_sel_type  key_sel;
      rsp_sel_type  rsp_sel;
   } dp_cmd_type;

   // Status bundle from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic empty;
      logic hole_root;
      logic parent_greater;
      logic has_child;
      logic child_smaller;
   } dp_stat_type;

   // Command that leaves the datapath untouched.
   localparam dp_cmd_type DP_NOP = '{
      rd_sel:   RD_NONE,
      wr_sel:   WR_NONE,
      hole_sel: HOLE_HOLD,
      cnt_sel:  CNT_HOLD,
      key_sel:  KEY_HOLD,
      rsp_sel:  RSP_NONE
   };

endpackage

/* src/bmhq_datapath.sv */
// ----------------------------------------------------------------------------
// bmhq_datapath
// Heap store with two registered read ports and one write port, the hole and
// count registers, key comparators, the capacity register and the result
// registers.
// ----------------------------------------------------------------------------
module bmhq_datapath #(
   parameter int HEAP_DEPTH = bmhq_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bmhq_pkg::dp_cmd_type          ctl,
   output bmhq_pkg::dp_stat_type         stat,
   input  logic [bmhq_pkg::KEY_W-1:0]    key_in,
   input  logic                          cap_we,
   input  logic [bmhq_pkg::CAP_W-1:0]    cap_data,
   output logic                          rsp_strobe,
   output logic [bmhq_pkg::KEY_W-1:0]    rsp_key,
   output logic [bmhq_pkg::STAT_W-1:0]   rsp_status,
   output logic [bmhq_pkg::OCC_W-1:0]    rsp_occupancy
);
   import bmhq_pkg::*;

   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int XW = (CW > CAP_W) ? CW : CAP_W;

   logic [KEY_W-1:0]  heap_mem_ff [HEAP_DEPTH];
   logic [KEY_W-1:0]  rd_a_ff, rd_b_ff;
   logic [KEY_W-1:0]  key_ff, key_in_w;
   logic [KEY_W-1:0]  min_ff, min_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     hole_ff, hole_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [CW:0]       left_pos, right_pos;
   logic [CW-1:0]     parent_pos;
   logic              rd_en, wr_en;
   logic [AW-1:0]     addr_a, addr_b, wr_addr;
   logic [KEY_W-1:0]  wr_data;
   logic              left_is_last, right_smaller;
   logic [KEY_W-1:0]  child_val;
   logic [CW:0]       child_pos;
   logic [XW-1:0]     occ_ext;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [KEY_W-1:0]  rsp_key_ff, rsp_key_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [OCC_W-1:0]  rsp_occ_ff, rsp_occ_in;

   // Heap positions count from one; the store entry is the position minus one.
   function automatic logic [AW-1:0] pos_addr(input logic [CW:0] pos);
      logic [CW:0] idx;
      idx = pos - 1'b1;
      return idx[AW-1:0];
   endfunction

   // Positions around the hole.
   assign left_pos   = {hole_ff, 1'b0};
   assign right_pos  = {hole_ff, 1'b1};
   assign parent_pos = hole_ff >> 1;

   // Smaller child, taking the left one on a tie or when it is the last entry.
   assign left_is_last  = (left_pos == {1'b0, count_ff});
   assign right_smaller = !left_is_last && ($signed(rd_b_ff) < $signed(rd_a_ff));
   assign child_val     = right_smaller ? rd_b_ff : rd_a_ff;
   assign child_pos     = right_smaller ? right_pos : left_pos;

   // Status toward the controller.
   always_comb begin
      stat.full = (XW'(count_ff) >= XW'(cap_ff)) || (count_ff >= CW'(HEAP_DEPTH));
      stat.empty = (count_ff == '0);
      stat.hole_root = (hole_ff == CW'(1));
      stat.parent_greater = ($signed(key_ff) < $signed(rd_a_ff));
      stat.has_child = (left_pos <= {1'b0, count_ff});
      stat.child_smaller = ($signed(child_val) < $signed(key_ff));
   end

   // Read address selection.
   always_comb begin
      rd_en = 1'b1;
      addr_a = '0;
      addr_b = '0;
      unique case (ctl.rd_sel)
         RD_NONE: begin
            rd_en = 1'b0;
         end
         RD_ROOT: begin
            addr_a = '0;
         end
         RD_PARENT: begin
            addr_a = pos_addr({1'b0, parent_pos});
         end
         RD_ROOT_LAST: begin
            addr_b = pos_addr({1'b0, count_ff});
         end
         RD_CHILDREN: begin
            addr_a = pos_addr(left_pos);
            addr_b = pos_addr(right_pos);
         end
      endcase
   end

   // Every write goes into the hole.
   always_comb begin
      wr_en = 1'b1;
      wr_addr = pos_addr({1'b0, hole_ff});
      wr_data = key_ff;
      unique case (ctl.wr_sel)
         WR_NONE:   wr_en = 1'b0;
         WR_KEY:    wr_data = key_ff;
         WR_PARENT: wr_data = rd_a_ff;
         WR_CHILD:  wr_data = child_val;
      endcase
   end

   // Heap store.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= heap_mem_ff[addr_a];
         rd_b_ff <= heap_mem_ff[addr_b];
      end
   end

   // Hole, count, key and minimum next values.
   always_comb begin
      unique case (ctl.hole_sel)
         HOLE_HOLD:   hole_in = hole_ff;
         HOLE_NEW:    hole_in = count_ff + 1'b1;
         HOLE_ROOT:   hole_in = CW'(1);
         HOLE_PARENT: hole_in = parent_pos;
         HOLE_CHILD:  hole_in = child_pos[CW-1:0];
      endcase
      unique case (ctl.cnt_sel)
         CNT_HOLD: count_in = count_ff;
         CNT_INC:  count_in = count_ff + 1'b1;
         CNT_DEC:  count_in = count_ff - 1'b1;
         CNT_CLR:  count_in = '0;
      endcase
      key_in_w = key_ff;
      min_in = min_ff;
      unique case (ctl.key_sel)
         KEY_HOLD: key_in_w = key_ff;
         KEY_REQ:  key_in_w = key_in;
         KEY_LAST: begin
            key_in_w = rd_b_ff;
            min_in = rd_a_ff;
         end
      endcase
      cap_in = cap_we ? cap_data : cap_ff;
   end

   // Result formation; occupancy is the count after the command.
   always_comb begin
      occ_ext = XW'(count_in);
      rsp_occ_in = occ_ext[OCC_W-1:0];
      rsp_strobe_in = 1'b1;
      rsp_key_in = '0;
      rsp_status_in = STAT_OK;
      unique case (ctl.rsp_sel)
         RSP_NONE:  rsp_strobe_in = 1'b0;
         RSP_OK:    rsp_status_in = STAT_OK;
         RSP_FULL:  rsp_status_in = STAT_FULL;
         RSP_EMPTY: begin
            rsp_key_in = SENTINEL_KEY;
            rsp_status_in = STAT_EMPTY;
         end
         RSP_MIN:   rsp_key_in = min_ff;
         RSP_ROOT:  rsp_key_in = rd_a_ff;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff <= CAP_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         cap_ff <= cap_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      hole_ff <= hole_in;
      key_ff <= key_in_w;
      min_ff <= min_in;
      if (rsp_strobe_in) begin
         rsp_key_ff <= rsp_key_in;
         rsp_status_ff <= rsp_status_in;
         rsp_occ_ff <= rsp_occ_in;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_key       = rsp_key_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

/* src/bmhq_ctrl.sv */
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Controller of the heap queue: walks sift-up for insert and sift-down for
// delete-min one level at a time and commands the datapath.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bmhq_pkg::CMD_W-1:0]  command,
   input  bmhq_pkg::dp_stat_type       stat,
   output bmhq_pkg::dp_cmd_type        ctl,
   output logic                        busy
);
   import bmhq_pkg::*;

   state_type state_ff, state_in;
   cmd_type   cmd_w;

   assign cmd_w = cmd_type'(command);
   assign busy  = (state_ff != ST_IDLE);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (cmd_w)
                  CMD_INSERT:     state_in = stat.full ? ST_IDLE : ST_INS_CHK;
                  CMD_DELETE_MIN: state_in = stat.empty ? ST_IDLE : ST_DEL_CAP;
                  CMD_FIND_MIN:   state_in = stat.empty ? ST_IDLE : ST_FIND_WAIT;
                  CMD_MAKE_EMPTY: state_in = ST_IDLE;
               endcase
            end
         end
         ST_INS_CHK:   state_in = stat.hole_root ? ST_IDLE : ST_INS_CMP;
         ST_INS_CMP:   state_in = stat.parent_greater ? ST_INS_CHK : ST_IDLE;
         ST_FIND_WAIT: state_in = ST_IDLE;
         ST_DEL_CAP:   state_in = ST_DEL_CHK;
         ST_DEL_CHK:   state_in = stat.has_child ? ST_DEL_CMP : ST_IDLE;
         ST_DEL_CMP:   state_in = stat.child_smaller ? ST_DEL_CHK : ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Datapath commands.
   always_comb begin
      ctl = DP_NOP;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (cmd_w)
                  CMD_INSERT: begin
                     if (stat.full) begin
                        ctl.rsp_sel = RSP_FULL;
                     end else begin
                        ctl.cnt_sel = CNT_INC;
                        ctl.hole_sel = HOLE_NEW;
                        ctl.key_sel = KEY_REQ;
                     end
                  end
                  CMD_DELETE_MIN: begin
                     if (stat.empty) begin
                        ctl.rsp_sel = RSP_EMPTY;
                     end else begin
                        ctl.rd_sel = RD_ROOT_LAST;
                        ctl.cnt_sel = CNT_DEC;
                        ctl.hole_sel = HOLE_ROOT;
                     end
                  end
                  CMD_FIND_MIN: begin
                     if (stat.empty) begin
                        ctl.rsp_sel = RSP_EMPTY;
                     end else begin
                        ctl.rd_sel = RD_ROOT;
                     end
                  end
                  CMD_MAKE_EMPTY: begin
                     ctl.cnt_sel = CNT_CLR;
                     ctl.rsp_sel = RSP_OK;
                  end
               endcase
            end
         end
         // Sift-up: place the key at the root or fetch the parent.
         ST_INS_CHK: begin
            if (stat.hole_root) begin
               ctl.wr_sel = WR_KEY;
               ctl.rsp_sel = RSP_OK;
            end else begin
               ctl.rd_sel = RD_PARENT;
            end
         end
         // Sift-up: move the parent down, or settle the key here.
         ST_INS_CMP: begin
            if (stat.parent_greater) begin
               ctl.wr_sel = WR_PARENT;
               ctl.hole_sel = HOLE_PARENT;
            end else begin
               ctl.wr_sel = WR_KEY;
               ctl.rsp_sel = RSP_OK;
            end
         end
         ST_FIND_WAIT: begin
            ctl.rsp_sel = RSP_ROOT;
         end
         // Capture the minimum and the last entry.
         ST_DEL_CAP: begin
            ctl.key_sel = KEY_LAST;
         end
         // Sift-down: fetch both children, or settle the last entry here.
         ST_DEL_CHK: begin
            if (stat.has_child) begin
               ctl.rd_sel = RD_CHILDREN;
            end else begin
               if (!stat.empty) begin
                  ctl.wr_sel = WR_KEY;
               end
               ctl.rsp_sel = RSP_MIN;
            end
         end
         // Sift-down: move the smaller child up, or settle the last entry.
         ST_DEL_CMP: begin
            if (stat.child_smaller) begin
               ctl.wr_sel = WR_CHILD;
               ctl.hole_sel = HOLE_CHILD;
            end else begin
               ctl.wr_sel = WR_KEY;
               ctl.rsp_sel = RSP_MIN;
            end
         end
         default: begin
            ctl = DP_NOP;
         end
      endcase
   end

endmodule

/* src/binary_min_heap_queue.sv */
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Binary min-heap priority queue of signed 32-bit keys with insert,
// delete-min, find-min and make-empty commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low, and its result
// shows on the rsp_ ports for exactly one cycle with rsp_strobe high; the
// receiver cannot stall, so results must be captured when strobed. The
// result comes in the cycle after the transaction for make-empty, a dropped
// insert and commands on an empty queue; find-min first reads the root and
// then answers from ST_FIND_WAIT. Insert answers once the key has climbed
// up to the root or stopped below a parent that is not greater, and
// delete-min once the last entry has sunk down to a leaf or stopped above a
// child that is not smaller. Each level costs one read of the single heap
// store and one compare-and-write, and a key moves at most log2 of
// HEAP_DEPTH levels. busy stays high until the result is issued. The store
// needs no clearing after reset. The capacity register may be written only
// while busy is low.
module binary_min_heap_queue #(
   parameter int HEAP_DEPTH = bmhq_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [bmhq_pkg::CMD_W-1:0]         req_command,
   input  logic signed [bmhq_pkg::KEY_W-1:0]  req_key_in,
   output logic                               rsp_strobe,
   output logic signed [bmhq_pkg::KEY_W-1:0]  rsp_key_out,
   output logic [bmhq_pkg::STAT_W-1:0]        rsp_status,
   output logic [bmhq_pkg::OCC_W-1:0]         rsp_occupancy,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bmhq_pkg::CAP_W-1:0]         csr_capacity_limit
);
   import bmhq_pkg::*;

   dp_cmd_type       ctl;
   dp_stat_type      stat;
   logic [KEY_W-1:0] rsp_key;

   // Capacity writes are taken whenever no command is in flight.
   assign csr_ready   = !busy;
   assign rsp_key_out = rsp_key;

   bmhq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_command),
      .stat    (stat),
      .ctl     (ctl),
      .busy    (busy)
   );

   bmhq_datapath #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .stat          (stat),
      .key_in        (req_key_in),
      .cap_we        (csr_valid && csr_ready),
      .cap_data      (csr_capacity_limit),
      .rsp_strobe    (rsp_strobe),
      .rsp_key       (rsp_key),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule

/* src/bmhq_checker.sv */
// ----------------------------------------------------------------------------
// bmhq_checker
// Port-level checks of the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
module bmhq_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_strobe,
   input logic signed [bmhq_pkg::KEY_W-1:0]  rsp_key_out,
   input logic [bmhq_pkg::STAT_W-1:0]        rsp_status,
   input logic [bmhq_pkg::OCC_W-1:0]         rsp_occupancy
);
   import bmhq_pkg::*;

   // An accepted transaction either keeps the block busy or is answered at once.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted transaction neither answered nor in progress");

   // A result is only issued for a transaction in flight.
   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) || $past(start)))
      else $error("result issued with no transaction in flight");

   // An empty report carries the sentinel and an empty queue.
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == STAT_EMPTY) |->
         (rsp_key_out == SENTINEL_KEY && rsp_occupancy == '0))
      else $error("empty result without sentinel or with nonzero occupancy");

   // A dropped insert returns a zero key.
   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == STAT_FULL) |-> (rsp_key_out == '0))
      else $error("full result with nonzero key");

endmodule

bind binary_min_heap_queue bmhq_checker u_bmhq_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_key_out   (rsp_key_out),
   .rsp_status    (rsp_status),
   .rsp_occupancy (rsp_occupancy)
);
